>>> hw/rtl/wtp_pkg.sv
`timescale 1ns / 1ps

package wtp_pkg;

    localparam int unsigned DW        = 47;
    localparam int unsigned SPAN_BITS = 16;
    localparam int unsigned CFG_IW    = 8;
    localparam int unsigned CFG_DW    = 32;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_SMALL = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_ACCURACY  = 2'd3;

    localparam logic [2:0] RNG_DIV2  = 3'd0;
    localparam logic [2:0] RNG_DIV4  = 3'd1;
    localparam logic [2:0] RNG_DIV8  = 3'd2;
    localparam logic [2:0] RNG_DIV16 = 3'd3;
    localparam logic [2:0] RNG_1HZ   = 3'd4;
    localparam logic [2:0] RNG_EXT   = 3'd5;

    localparam logic [2:0] CS_DIV16 = 3'd0;
    localparam logic [2:0] CS_DIV8  = 3'd1;
    localparam logic [2:0] CS_DIV4  = 3'd2;
    localparam logic [2:0] CS_DIV2  = 3'd3;
    localparam logic [2:0] CS_1HZ   = 3'd4;
    localparam logic [2:0] CS_EXT   = 3'd6;

    localparam logic [CFG_IW-1:0] CFG_DRIFT = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] CFG_NOISE = CFG_IW'(1);

    localparam logic [9:0]  DRIFT_RST = 10'd50;
    localparam logic [19:0] NOISE_RST = 20'd30517;
    localparam logic [19:0] PPM_SCALE = 20'd1000000;

    localparam logic [29:0] PER_DIV2  = 30'd61035;
    localparam logic [29:0] PER_DIV4  = 30'd122070;
    localparam logic [29:0] PER_DIV8  = 30'd244141;
    localparam logic [29:0] PER_DIV16 = 30'd488281;
    localparam logic [29:0] PER_1HZ   = 30'd1000000000;

    localparam logic [63:0] LIM_SMALL = 64'(PER_DIV2) * 64'd2;
    localparam logic [63:0] LIM_DIV2  = 64'(PER_DIV2) << SPAN_BITS;
    localparam logic [63:0] LIM_DIV4  = 64'(PER_DIV4) << SPAN_BITS;
    localparam logic [63:0] LIM_DIV8  = 64'(PER_DIV8) << SPAN_BITS;
    localparam logic [63:0] LIM_DIV16 = 64'(PER_DIV16) << SPAN_BITS;
    localparam logic [63:0] LIM_1HZ   = 64'(PER_1HZ) << SPAN_BITS;
    localparam logic [63:0] LIM_EXT   = 64'(PER_1HZ) << (SPAN_BITS + 1);

    // reciprocal shift per range: 2**shift is above the range's largest delay
    localparam logic [5:0] SH_DIV2  = 6'd32;
    localparam logic [5:0] SH_DIV4  = 6'd33;
    localparam logic [5:0] SH_DIV8  = 6'd34;
    localparam logic [5:0] SH_DIV16 = 6'd35;
    localparam logic [5:0] SH_1HZ   = 6'd46;
    localparam logic [5:0] SH_EXT   = 6'd47;

    localparam logic [17:0] REC_DIV2  = 18'((64'd1 << SH_DIV2) / 64'(PER_DIV2));
    localparam logic [17:0] REC_DIV4  = 18'((64'd1 << SH_DIV4) / 64'(PER_DIV4));
    localparam logic [17:0] REC_DIV8  = 18'((64'd1 << SH_DIV8) / 64'(PER_DIV8));
    localparam logic [17:0] REC_DIV16 = 18'((64'd1 << SH_DIV16) / 64'(PER_DIV16));
    localparam logic [17:0] REC_1HZ   = 18'((64'd1 << SH_1HZ) / 64'(PER_1HZ));
    localparam logic [17:0] REC_EXT   = 18'((64'd1 << SH_EXT) / 64'(PER_1HZ));

    typedef struct packed {
        logic [DW-1:0] delay;
        logic [2:0]    rng;
        logic [1:0]    st;
        logic          chk;
        logic          bad;
        logic [30:0]   diff;
    } t_front;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } t_pipe_en;

    function automatic logic [29:0] f_period(input logic [2:0] rng);
        logic [29:0] p;
        unique case (rng)
            RNG_DIV2:  p = PER_DIV2;
            RNG_DIV4:  p = PER_DIV4;
            RNG_DIV8:  p = PER_DIV8;
            RNG_DIV16: p = PER_DIV16;
            RNG_1HZ:   p = PER_1HZ;
            RNG_EXT:   p = PER_1HZ;
            default:   p = PER_1HZ;
        endcase
        return p;
    endfunction

    function automatic logic [17:0] f_recip(input logic [2:0] rng);
        logic [17:0] m;
        unique case (rng)
            RNG_DIV2:  m = REC_DIV2;
            RNG_DIV4:  m = REC_DIV4;
            RNG_DIV8:  m = REC_DIV8;
            RNG_DIV16: m = REC_DIV16;
            RNG_1HZ:   m = REC_1HZ;
            RNG_EXT:   m = REC_EXT;
            default:   m = REC_EXT;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] f_shift(input logic [2:0] rng);
        logic [5:0] s;
        unique case (rng)
            RNG_DIV2:  s = SH_DIV2;
            RNG_DIV4:  s = SH_DIV4;
            RNG_DIV8:  s = SH_DIV8;
            RNG_DIV16: s = SH_DIV16;
            RNG_1HZ:   s = SH_1HZ;
            RNG_EXT:   s = SH_EXT;
            default:   s = SH_EXT;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] f_sel(input logic [2:0] rng);
        logic [2:0] c;
        unique case (rng)
            RNG_DIV2:  c = CS_DIV2;
            RNG_DIV4:  c = CS_DIV4;
            RNG_DIV8:  c = CS_DIV8;
            RNG_DIV16: c = CS_DIV16;
            RNG_1HZ:   c = CS_1HZ;
            RNG_EXT:   c = CS_EXT;
            default:   c = CS_EXT;
        endcase
        return c;
    endfunction

endpackage

>>> hw/rtl/wakeup_timer_planner.sv
`timescale 1ns / 1ps

// channel   direction  handshake               payload
// request   in         i_in_valid/o_in_stall   i_delay_ns, i_required_ppm
// result    out        o_out_valid/i_out_stall o_status, o_clock_select, o_reload
// config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// Six register stages: range select, products, wide sums, quotient
// estimate, back-multiply, correction. One item per cycle unless the result
// is stalled. Each stage moves on when it is empty or the next one moves, so
// bubbles close up behind a stalled result. Reset clears the stage valid bits
// and loads drift 50 ppm, noise 30517 ns. Config write always ready.

module wakeup_timer_planner import wtp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [63:0]        i_delay_ns,
    input  logic signed [31:0] i_required_ppm,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [2:0]         o_clock_select,
    output logic [15:0]        o_reload,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_IW-1:0]  i_cfg_index,
    input  logic [CFG_DW-1:0]  i_cfg_data
);

    logic [9:0]  r_drift;
    logic [19:0] r_noise;
    logic [6:1]  r_v;
    logic [1:0]  r_st2;
    logic [1:0]  r_st3;
    logic [1:0]  r_st4;
    logic [1:0]  r_st5;
    logic [1:0]  r_st6;
    logic [2:0]  r_sel2;
    logic [2:0]  r_sel3;
    logic [2:0]  r_sel4;
    logic [2:0]  r_sel5;
    logic [2:0]  r_sel6;

    t_pipe_en    w_en;
    t_front      w_front;
    logic        w_fail;
    logic [15:0] w_reload;

    always_comb begin
        w_en.s6 = !r_v[6] || !i_out_stall;
        w_en.s5 = !r_v[5] || w_en.s6;
        w_en.s4 = !r_v[4] || w_en.s5;
        w_en.s3 = !r_v[3] || w_en.s4;
        w_en.s2 = !r_v[2] || w_en.s3;
        w_en.s1 = !r_v[1] || w_en.s2;
    end

    assign o_in_stall  = !w_en.s1;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drift <= DRIFT_RST;
            r_noise <= NOISE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DRIFT: r_drift <= i_cfg_data[9:0];
                CFG_NOISE: r_noise <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en.s1) r_v[1] <= i_in_valid;
            if (w_en.s2) r_v[2] <= r_v[1];
            if (w_en.s3) r_v[3] <= r_v[2];
            if (w_en.s4) r_v[4] <= r_v[3];
            if (w_en.s5) r_v[5] <= r_v[4];
            if (w_en.s6) r_v[6] <= r_v[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en.s2) begin
            r_st2  <= w_front.st;
            r_sel2 <= f_sel(w_front.rng);
        end
        if (w_en.s3) begin
            r_st3  <= r_st2;
            r_sel3 <= r_sel2;
        end
        if (w_en.s4) begin
            r_st4  <= (r_st3 == ST_OK && w_fail) ? ST_ACCURACY : r_st3;
            r_sel4 <= r_sel3;
        end
        if (w_en.s5) begin
            r_st5  <= r_st4;
            r_sel5 <= r_sel4;
        end
        if (w_en.s6) begin
            r_st6  <= r_st5;
            r_sel6 <= (r_st5 == ST_OK) ? r_sel5 : 3'd0;
        end
    end

    wtp_front u_front (
        .i_clk          (i_clk),
        .i_en           (w_en.s1),
        .i_delay_ns     (i_delay_ns),
        .i_required_ppm (i_required_ppm),
        .i_drift_ppm    (r_drift),
        .o_front        (w_front)
    );

    wtp_accuracy u_accuracy (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_front    (w_front),
        .i_noise_ns (r_noise),
        .o_fail     (w_fail)
    );

    wtp_quotient u_quotient (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_front  (w_front),
        .o_reload (w_reload)
    );

    assign o_out_valid    = r_v[6];
    assign o_status       = r_st6;
    assign o_clock_select = r_sel6;
    assign o_reload       = (r_st6 == ST_OK) ? w_reload : 16'd0;

endmodule

>>> hw/rtl/wtp_front.sv
`timescale 1ns / 1ps

module wtp_front import wtp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [63:0]        i_delay_ns,
    input  logic signed [31:0] i_required_ppm,
    input  logic [9:0]         i_drift_ppm,
    output t_front             o_front
);

    t_front      n_front;
    t_front      r_front;
    logic [32:0] w_diff;

    assign w_diff = {1'b0, i_required_ppm} - {23'd0, i_drift_ppm};

    always_comb begin
        n_front       = '0;
        n_front.delay = i_delay_ns[DW-1:0];
        n_front.st    = ST_OK;
        n_front.rng   = RNG_DIV2;
        if (i_delay_ns < LIM_SMALL) begin
            n_front.st = ST_TOO_SMALL;
        end else if (i_delay_ns < LIM_DIV2) begin
            n_front.rng = RNG_DIV2;
        end else if (i_delay_ns < LIM_DIV4) begin
            n_front.rng = RNG_DIV4;
        end else if (i_delay_ns < LIM_DIV8) begin
            n_front.rng = RNG_DIV8;
        end else if (i_delay_ns < LIM_DIV16) begin
            n_front.rng = RNG_DIV16;
        end else if (i_delay_ns < LIM_1HZ) begin
            n_front.rng = RNG_1HZ;
        end else if (i_delay_ns < LIM_EXT) begin
            n_front.rng = RNG_EXT;
        end else begin
            n_front.st = ST_RANGE;
        end
        // sign bit clear means a demand is given
        n_front.chk  = ~i_required_ppm[31];
        n_front.bad  = w_diff[32] || (w_diff == 33'd0);
        n_front.diff = w_diff[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;

endmodule

>>> hw/rtl/wtp_accuracy.sv
`timescale 1ns / 1ps

module wtp_accuracy import wtp_pkg::*; (
    input  logic        i_clk,
    input  t_pipe_en    i_en,
    input  t_front      i_front,
    input  logic [19:0] i_noise_ns,
    output logic        o_fail
);

    logic [54:0] r_plo;
    logic [53:0] r_phi;
    logic [50:0] r_rhs;
    logic        r_chk;
    logic        r_bad;
    logic        r_fail;

    logic [30:0] w_psum;
    logic [77:0] w_prod;

    assign w_psum = 31'(f_period(i_front.rng)) + 31'(i_noise_ns);
    assign w_prod = {r_phi, 24'd0} + 78'(r_plo);

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_plo <= 55'(i_front.diff) * 55'(i_front.delay[23:0]);
            r_phi <= 54'(i_front.diff) * 54'(i_front.delay[DW-1:24]);
            r_rhs <= 51'(w_psum) * 51'(PPM_SCALE);
            r_chk <= i_front.chk;
            r_bad <= i_front.bad;
        end
        if (i_en.s3) begin
            r_fail <= r_chk && (r_bad || (w_prod < 78'(r_rhs)));
        end
    end

    assign o_fail = r_fail;

endmodule

>>> hw/rtl/wtp_quotient.sv
`timescale 1ns / 1ps

module wtp_quotient import wtp_pkg::*; (
    input  logic        i_clk,
    input  t_pipe_en    i_en,
    input  t_front      i_front,
    output logic [15:0] o_reload
);

    logic [41:0]   r_qlo;
    logic [40:0]   r_qhi;
    logic [64:0]   r_qsum;
    logic [16:0]   r_q4;
    logic [16:0]   r_q5;
    logic [DW-1:0] r_t5;
    logic [DW-1:0] r_d2;
    logic [DW-1:0] r_d3;
    logic [DW-1:0] r_d4;
    logic [DW-1:0] r_d5;
    logic [2:0]    r_rng2;
    logic [2:0]    r_rng3;
    logic [2:0]    r_rng4;
    logic [2:0]    r_rng5;
    logic [15:0]   r_reload;

    logic [17:0]   w_rec;
    logic [DW-1:0] w_rem;
    logic [16:0]   n_q;

    assign w_rec = f_recip(i_front.rng);
    // estimate is exact or one short
    assign w_rem = r_d5 - r_t5;
    assign n_q   = r_q5 + 17'(w_rem >= DW'(f_period(r_rng5)));

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_qlo  <= 42'(i_front.delay[23:0]) * 42'(w_rec);
            r_qhi  <= 41'(i_front.delay[DW-1:24]) * 41'(w_rec);
            r_d2   <= i_front.delay;
            r_rng2 <= i_front.rng;
        end
        if (i_en.s3) begin
            r_qsum <= {r_qhi, 24'd0} + 65'(r_qlo);
            r_d3   <= r_d2;
            r_rng3 <= r_rng2;
        end
        if (i_en.s4) begin
            r_q4   <= 17'(r_qsum >> f_shift(r_rng3));
            r_d4   <= r_d3;
            r_rng4 <= r_rng3;
        end
        if (i_en.s5) begin
            r_t5   <= DW'(r_q4) * DW'(f_period(r_rng4));
            r_q5   <= r_q4;
            r_d5   <= r_d4;
            r_rng5 <= r_rng4;
        end
        if (i_en.s6) begin
            r_reload <= 16'(n_q - 17'd1);
        end
    end

    assign o_reload = r_reload;

endmodule

>>> dv/tb_wakeup_timer_planner.sv
`timescale 1ns / 1ps

localparam logic [63:0] SPAN      = 64'd65536;
localparam logic [63:0] P_D2      = 64'd61035;
localparam logic [63:0] P_D4      = 64'd122070;
localparam logic [63:0] P_D8      = 64'd244141;
localparam logic [63:0] P_D16     = 64'd488281;
localparam logic [63:0] P_SEC     = 64'd1000000000;
localparam logic [63:0] TOP_SMALL = P_D2 * 64'd2;
localparam logic [63:0] TOP_D2    = P_D2 * SPAN;
localparam logic [63:0] TOP_D4    = P_D4 * SPAN;
localparam logic [63:0] TOP_D8    = P_D8 * SPAN;
localparam logic [63:0] TOP_D16   = P_D16 * SPAN;
localparam logic [63:0] TOP_SEC   = P_SEC * SPAN;
localparam logic [63:0] TOP_EXT   = P_SEC * SPAN * 64'd2;

class wake_plan_board;
    typedef struct {
        logic [63:0]        delay;
        logic signed [31:0] ppm;
        logic [1:0]         status;
        logic [2:0]         clock_select;
        logic [15:0]        reload;
    } t_plan;

    t_plan       plans[$];
    logic [9:0]  drift;
    logic [19:0] noise;
    int unsigned mismatches;

    function new();
        drift      = 10'd50;
        noise      = 20'd30517;
        mismatches = 0;
    endfunction

    function void write_reg(logic [wtp_pkg::CFG_IW-1:0] index,
                            logic [wtp_pkg::CFG_DW-1:0] data);
        if (index == wtp_pkg::CFG_DRIFT) begin
            drift = data[9:0];
        end else if (index == wtp_pkg::CFG_NOISE) begin
            noise = data[19:0];
        end
    endfunction

    function void note_request(logic [63:0] delay, logic signed [31:0] ppm);
        t_plan        p;
        logic [63:0]  period;
        longint       margin;
        logic [127:0] lhs;
        logic [127:0] rhs;
        p.delay        = delay;
        p.ppm          = ppm;
        p.status       = wtp_pkg::ST_OK;
        p.clock_select = 3'd0;
        p.reload       = 16'd0;
        period         = P_SEC;
        if (delay < TOP_SMALL) begin
            p.status = wtp_pkg::ST_TOO_SMALL;
        end else if (delay >= TOP_EXT) begin
            p.status = wtp_pkg::ST_RANGE;
        end else begin
            if (delay < TOP_D2) begin
                period = P_D2;  p.clock_select = wtp_pkg::CS_DIV2;
            end else if (delay < TOP_D4) begin
                period = P_D4;  p.clock_select = wtp_pkg::CS_DIV4;
            end else if (delay < TOP_D8) begin
                period = P_D8;  p.clock_select = wtp_pkg::CS_DIV8;
            end else if (delay < TOP_D16) begin
                period = P_D16; p.clock_select = wtp_pkg::CS_DIV16;
            end else if (delay < TOP_SEC) begin
                period = P_SEC; p.clock_select = wtp_pkg::CS_1HZ;
            end else begin
                period = P_SEC; p.clock_select = wtp_pkg::CS_EXT;
            end
            if (!ppm[31]) begin
                // exact wide compare, no wrap
                margin = longint'(ppm) - longint'(drift);
                lhs    = 128'(margin) * 128'(delay);
                rhs    = 128'(period + 64'(noise)) * 128'd1000000;
                if (margin <= 0 || lhs < rhs) p.status = wtp_pkg::ST_ACCURACY;
            end
            if (p.status == wtp_pkg::ST_OK) begin
                p.reload = 16'(delay / period - 64'd1);
            end else begin
                p.clock_select = 3'd0;
            end
        end
        plans.push_back(p);
    endfunction

    function void check_result(logic [1:0] status, logic [2:0] clock_select,
                               logic [15:0] reload);
        t_plan p;
        if (plans.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected item: st %0d cs %0d reload %0d",
                         status, clock_select, reload);
        end else begin
            p = plans.pop_front();
            if (status !== p.status || clock_select !== p.clock_select ||
                reload !== p.reload) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch delay %0d ppm %0d: ",
                              "exp st %0d cs %0d reload %0d, ",
                              "got st %0d cs %0d reload %0d"},
                             p.delay, p.ppm, p.status, p.clock_select, p.reload,
                             status, clock_select, reload);
            end
        end
    endfunction
endclass

module tb_wakeup_timer_planner;
    import wtp_pkg::*;

    localparam logic [CFG_IW-1:0] CFG_SPARE     = CFG_IW'(2);
    localparam logic [CFG_IW-1:0] CFG_TOP_INDEX = {CFG_IW{1'b1}};
    localparam int                SETTLE_CYCLES = 20;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_stall;
    logic [63:0]        i_delay_ns     = 64'd0;
    logic signed [31:0] i_required_ppm = 32'sd0;
    logic               o_out_valid;
    logic               i_out_stall    = 1'b0;
    logic [1:0]         o_status;
    logic [2:0]         o_clock_select;
    logic [15:0]        o_reload;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_IW-1:0]  i_cfg_index    = '0;
    logic [CFG_DW-1:0]  i_cfg_data     = '0;

    wake_plan_board board = new();
    bit             no_idle = 1'b0;

    wakeup_timer_planner uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] range_floor(int k);
        case (k)
            0:       return TOP_SMALL;
            1:       return TOP_D2;
            2:       return TOP_D4;
            3:       return TOP_D8;
            4:       return TOP_D16;
            5:       return TOP_SEC;
            default: return TOP_EXT;
        endcase
    endfunction

    function automatic logic [63:0] range_period(int k);
        case (k)
            0:       return P_D2;
            1:       return P_D4;
            2:       return P_D8;
            3:       return P_D16;
            default: return P_SEC;
        endcase
    endfunction

    task automatic send_request(logic [63:0] delay, logic signed [31:0] ppm);
        int gap;
        gap = no_idle ? 0 : idle_len();
        i_cfg_valid <= 1'b0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_delay_ns     <= delay;
        i_required_ppm <= ppm;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(delay, ppm);
    endtask

    task automatic write_register(logic [CFG_IW-1:0] index, logic [CFG_DW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(index, data);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (board.plans.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_request();
        int          r;
        int          k;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] d;
        logic [63:0] need;
        longint      thr;
        logic [31:0] ppm;
        r   = $urandom_range(0, 99);
        ppm = $urandom;
        if (r < 75) begin
            k  = $urandom_range(0, 5);
            lo = range_floor(k);
            hi = range_floor(k + 1);
            case ($urandom_range(0, 3))
                0:       d = lo + 64'($urandom_range(0, 3));
                1:       d = hi - 64'd1 - 64'($urandom_range(0, 3));
                default: d = lo + ({$urandom, $urandom} % (hi - lo));
            endcase
            r = $urandom_range(0, 99);
            if (r < 25) begin
                ppm[31] = 1'b1;
            end else if (r < 60) begin
                // straddle the accuracy threshold
                need = ((range_period(k) + 64'(board.noise)) * 64'd1000000 + d - 64'd1) / d;
                thr  = longint'(need) + longint'(board.drift) +
                       longint'($urandom_range(0, 4)) - 2;
                if (thr < 0) thr = 0;
                if (thr > 64'sh7FFF_FFFF) ppm[31] = 1'b0;
                else ppm = 32'(thr);
            end else if (r < 75) begin
                thr = longint'(board.drift) + longint'($urandom_range(0, 2)) - 1;
                if (thr < 0) thr = 0;
                ppm = 32'(thr);
            end else if (r < 90) begin
                ppm = $urandom_range(0, 100000);
            end else begin
                ppm[31] = 1'b0;
            end
        end else if (r < 85) begin
            d = 64'($urandom_range(0, 122069));
        end else if (r < 92) begin
            d = {$urandom, $urandom} | (64'd1 << $urandom_range(47, 63));
        end else begin
            d = {$urandom, $urandom};
        end
        send_request(d, ppm);
    endtask

    task automatic random_phase(int count);
        repeat (count) random_request();
        drain_results();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_result(o_status, o_clock_select, o_reload);
    end

    initial begin
        int run;
        int hold;
        forever begin
            i_out_stall <= 1'b0;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
            repeat (run) @(posedge i_clk);
            hold = idle_len();
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    initial begin
        #5ms;
        $display("tb_wakeup_timer_planner: FAIL");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, range edges and threshold edges
        send_request(64'd0, -32'sd1);
        send_request(TOP_SMALL - 64'd1, -32'sd1);
        send_request(TOP_SMALL, -32'sd1);
        send_request(TOP_D2 - 64'd1, -32'sd1);
        send_request(TOP_D2, -32'sd1);
        send_request(TOP_D4 - 64'd1, 32'sd0);
        send_request(TOP_D4, 32'sd50);
        send_request(TOP_D8 - 64'd1, 32'sd51);
        send_request(TOP_D8, 32'sh7FFF_FFFF);
        send_request(TOP_D16 - 64'd1, 32'sh7FFF_FFFF);
        send_request(TOP_D16, 32'sh8000_0000);
        send_request(TOP_SEC - 64'd1, -32'sd1);
        send_request(TOP_SEC, -32'sd1);
        send_request(TOP_EXT - 64'd1, -32'sd1);
        send_request(TOP_EXT, -32'sd1);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 32'sh7FFF_FFFF);
        send_request(64'd91552000, 32'sd1050);
        send_request(64'd91551999, 32'sd1050);
        send_request(64'hAAAA_AAAA_AAAA_AAAA, 32'sh5555_5555);
        send_request(64'h5555_5555, 32'shAAAA_AAAA);
        send_request(TOP_D16 + 64'd12345, 32'sd100);
        drain_results();

        write_register(CFG_DRIFT, '0);
        write_register(CFG_NOISE, '0);
        random_phase(100);

        no_idle = 1'b1;
        write_register(CFG_DRIFT, CFG_DW'(1000));
        write_register(CFG_NOISE, CFG_DW'(1000000));
        random_phase(100);
        no_idle = 1'b0;

        // oversized data is masked, unknown indexes ignored
        write_register(CFG_DRIFT, {CFG_DW{1'b1}});
        write_register(CFG_NOISE, {CFG_DW{1'b1}});
        write_register(CFG_SPARE, $urandom);
        write_register(CFG_TOP_INDEX, $urandom);
        random_phase(100);

        repeat (4) begin
            write_register(CFG_DRIFT, CFG_DW'($urandom_range(0, 1000)));
            write_register(CFG_NOISE, CFG_DW'($urandom_range(0, 1000000)));
            random_phase(100);
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.plans.size() == 0) begin
            $display("tb_wakeup_timer_planner: PASS");
        end else begin
            $display("tb_wakeup_timer_planner: FAIL");
        end
        $finish;
    end
endmodule
